/* hw/rtl/rps_pkg.sv */
// Shared types and constants of the rotation period and slice tracker.
`default_nettype none

package rps_pkg;

    localparam int VAL_W       = 32;
    localparam int STAB_W      = 16;
    localparam int SLICE_W     = 6;
    localparam int EVENT_W     = 3;
    localparam int SLICE_CFG_W = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [VAL_W-1:0]       AVG_RESET     = 32'd250000;
    localparam logic [SLICE_CFG_W-1:0] SLICE_RESET   = 7'd60;
    localparam logic [STAB_W-1:0]      SLACK_RESET   = 16'd20;
    localparam logic [STAB_W-1:0]      STAB_MAX      = 16'hFFFF;
    localparam logic [VAL_W-1:0]       BLEND_DIVISOR = 32'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLICE_COUNT  = 2'd0,
        CFG_RETIME_SLACK = 2'd1
    } t_cfg_index;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_SPURIOUS = 3'd1,
        EV_MISSED   = 3'd2,
        EV_RETIMED  = 3'd3,
        EV_STEADY   = 3'd4
    } t_event;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_BLEND,
        S_RETIME,
        S_PAINT,
        S_PAINT_WAIT,
        S_MOD,
        S_MOD_WAIT,
        S_SPLIT,
        S_SLICE,
        S_SLICE_WAIT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/rps_cfg.sv */
// Configuration registers: slice count with clamping and retime slack.
`default_nettype none

module rps_cfg
    import rps_pkg::*;
#(
    parameter int SLICE_LIMIT = 64,
    parameter int NB          = 7
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic [NB-1:0]               o_slices,
    output logic [STAB_W-1:0]           o_slack,
    output logic                        o_wr
);

    localparam int CMP_W = 10;

    logic [SLICE_CFG_W-1:0] r_slice_count;
    logic [STAB_W-1:0]      r_slack;
    logic [CMP_W-1:0]       w_sc_ext;

    assign o_cfg_ready = 1'b1;
    assign o_wr        = i_cfg_valid;

    // Take a register write on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_count <= SLICE_RESET;
            r_slack       <= SLACK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLICE_COUNT:  r_slice_count <= i_cfg_data[SLICE_CFG_W-1:0];
                CFG_RETIME_SLACK: r_slack       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the slice count into one to the slice limit
    assign w_sc_ext = CMP_W'(r_slice_count);

    always_comb begin
        if (r_slice_count == '0) begin
            o_slices = NB'(1);
        end else if (w_sc_ext > CMP_W'(SLICE_LIMIT)) begin
            o_slices = NB'(SLICE_LIMIT);
        end else begin
            o_slices = NB'(r_slice_count);
        end
    end

    assign o_slack = r_slack;

endmodule

`default_nettype wire

/* hw/rtl/rps_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module rps_div #(
    parameter int DW = 37,
    parameter int VW = 32,
    parameter int CW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [CW-1:0] i_count,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_rem_init,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_busy,
    output logic [DW-1:0]      o_quot,
    output logic [VW-1:0]      o_rem
);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dsr;
    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;
    logic          w_ge;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = !w_diff[VW];

    // Hold the busy flag and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_count;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Shift the dividend out and the quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= i_rem_init;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* hw/rtl/rotation_period_slice_tracker.sv */
// An accepted rising hall edge also runs the average update through the divider; a rejected
// one skips it. A changed period or any configuration write also recomputes the paint interval.
// One item at a time: the next is taken only once the result is registered and the tracker
// is back in idle; a stalled result holds the block. One bit-serial divider is shared.
// Reset (synchronous, active low): hall high, period/average 250000, stability 0, no result.
`default_nettype none

module rotation_period_slice_tracker
    import rps_pkg::*;
#(
    parameter int SLICE_LIMIT = 64,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [TIME_BITS-1:0]   i_now_us,
    input  wire logic                   i_hall_level,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [SLICE_W-1:0]          o_slice_index,
    output logic                        o_mirrored,
    output logic [EVENT_W-1:0]          o_event_res,
    output logic [VAL_W-1:0]            o_period_us,
    output logic [VAL_W-1:0]            o_paint_interval_us,
    output logic [STAB_W-1:0]           o_stable_count,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NB    = $clog2(SLICE_LIMIT + 1);
    localparam int SW    = ((TIME_BITS > 36) ? TIME_BITS : 36) + 1;
    localparam int DW    = SW;
    localparam int CW    = $clog2(DW + 1);
    localparam int CMPW  = (TIME_BITS > 33) ? TIME_BITS : 33;
    localparam int PW    = VAL_W + NB;

    // Configuration
    logic [NB-1:0]     w_slices;
    logic [STAB_W-1:0] w_slack;
    logic              w_cfg_wr;

    rps_cfg #(
        .SLICE_LIMIT (SLICE_LIMIT),
        .NB          (NB)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_slices    (w_slices),
        .o_slack     (w_slack),
        .o_wr        (w_cfg_wr)
    );

    // Shared divider
    logic             w_div_start;
    logic [CW-1:0]    w_div_count;
    logic [DW-1:0]    w_div_dividend;
    logic [VAL_W-1:0] w_div_rem_init;
    logic [VAL_W-1:0] w_div_divisor;
    logic             w_div_busy;
    logic [DW-1:0]    w_div_quot;
    logic [VAL_W-1:0] w_div_rem;

    rps_div #(
        .DW (DW),
        .VW (VAL_W),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_count    (w_div_count),
        .i_dividend (w_div_dividend),
        .i_rem_init (w_div_rem_init),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // Tracker state and item registers
    t_state                r_state;
    t_state                n_state;
    logic [TIME_BITS-1:0]  r_now;
    logic                  r_hall_prev;
    logic [TIME_BITS-1:0]  r_cycle_start;
    logic [VAL_W-1:0]      r_avg;
    logic [VAL_W-1:0]      r_period;
    logic [STAB_W-1:0]     r_stab;
    t_event                r_event;
    logic [VAL_W-1:0]      r_paint;
    logic                  r_paint_ok;
    logic [VAL_W-1:0]      r_nt;
    logic [VAL_W-1:0]      r_u;
    logic [VAL_W-1:0]      r_x;
    logic [VAL_W-1:0]      r_d;
    logic                  r_mir;
    logic [SLICE_W-1:0]    r_slice;

    logic                  r_out_valid;
    logic [SLICE_W-1:0]    r_out_slice;
    logic                  r_out_mir;
    t_event                r_out_event;
    logic [VAL_W-1:0]      r_out_period;
    logic [VAL_W-1:0]      r_out_paint;
    logic [STAB_W-1:0]     r_out_stab;

    // Combinational datapath
    logic                  w_accept;
    logic                  w_rise;
    logic                  w_out_free;
    logic [TIME_BITS-1:0]  w_elapsed;
    logic [CMPW-1:0]       w_p_ext;
    logic [CMPW-1:0]       w_avg_half;
    logic [CMPW-1:0]       w_avg_hi;
    logic                  w_spur;
    logic                  w_miss;
    logic [SW-1:0]         w_blend_sum;
    logic [VAL_W-1:0]      w_nt_sat;
    logic [VAL_W-1:0]      w_nt_diff;
    logic [VAL_W-1:0]      w_half_period;
    logic [PW-1:0]         w_prod;
    logic                  w_in_stall;

    assign w_accept   = i_in_valid && !w_in_stall;
    assign w_rise     = !r_hall_prev && i_hall_level;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_elapsed  = r_now - r_cycle_start;

    // Reject tests against half and one and a half times the average
    assign w_p_ext    = CMPW'(w_elapsed);
    assign w_avg_half = CMPW'(r_avg[VAL_W-1:1]);
    assign w_avg_hi   = CMPW'(r_avg) + CMPW'(r_avg[VAL_W-1:1]);
    assign w_spur     = (r_stab != '0) && (w_p_ext < w_avg_half);
    assign w_miss     = (r_stab != '0) && (w_p_ext > w_avg_hi);

    // Nine times the average plus the new period, to be divided by ten
    assign w_blend_sum = (SW'(r_avg) << 3) + SW'(r_avg) + SW'(w_elapsed);
    assign w_nt_sat    = (w_div_quot[DW-1:VAL_W] != '0) ? '1 : w_div_quot[VAL_W-1:0];
    assign w_nt_diff   = (r_period > r_nt) ? (r_period - r_nt) : (r_nt - r_period);

    assign w_half_period = {1'b0, r_period[VAL_W-1:1]};
    assign w_prod        = PW'(r_x) * PW'(w_slices);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_rise ? S_EDGE : S_PAINT;
                end
            end
            S_EDGE: begin
                n_state = (w_spur || w_miss) ? S_PAINT : S_BLEND;
            end
            S_BLEND: begin
                if (!w_div_busy) begin
                    n_state = S_RETIME;
                end
            end
            S_RETIME: begin
                n_state = S_PAINT;
            end
            S_PAINT: begin
                n_state = r_paint_ok ? S_MOD : S_PAINT_WAIT;
            end
            S_PAINT_WAIT: begin
                if (!w_div_busy) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_state = (r_period == '0) ? S_SPLIT : S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (!w_div_busy) begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                n_state = S_SLICE;
            end
            S_SLICE: begin
                n_state = (r_d == '0) ? S_DONE : S_SLICE_WAIT;
            end
            S_SLICE_WAIT: begin
                if (!w_div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: input stall and divider launches
    always_comb begin
        w_in_stall     = 1'b1;
        w_div_start    = 1'b0;
        w_div_count    = '0;
        w_div_dividend = '0;
        w_div_rem_init = '0;
        w_div_divisor  = '0;
        case (r_state)
            S_IDLE: begin
                w_in_stall = 1'b0;
            end
            S_EDGE: begin
                if (!w_spur && !w_miss) begin
                    w_div_start    = 1'b1;
                    w_div_count    = CW'(DW);
                    w_div_dividend = w_blend_sum;
                    w_div_divisor  = BLEND_DIVISOR;
                end
            end
            S_PAINT: begin
                if (!r_paint_ok) begin
                    w_div_start    = 1'b1;
                    w_div_count    = CW'(VAL_W);
                    w_div_dividend = {w_half_period, {(DW-VAL_W){1'b0}}};
                    w_div_divisor  = VAL_W'(w_slices);
                end
            end
            S_MOD: begin
                if (r_period != '0) begin
                    w_div_start    = 1'b1;
                    w_div_count    = CW'(TIME_BITS);
                    w_div_dividend = {w_elapsed, {(DW-TIME_BITS){1'b0}}};
                    w_div_divisor  = r_period;
                end
            end
            S_SLICE: begin
                if (r_d != '0) begin
                    w_div_start    = 1'b1;
                    w_div_count    = CW'(NB);
                    w_div_dividend = {w_prod[NB-1:0], {(DW-NB){1'b0}}};
                    w_div_rem_init = w_prod[PW-1:NB];
                    w_div_divisor  = r_d;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall = w_in_stall;

    // Advance the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tracker state: hall level, cycle start, average, period, stability, paint cache
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hall_prev   <= 1'b1;
            r_cycle_start <= '0;
            r_avg         <= AVG_RESET;
            r_period      <= AVG_RESET;
            r_stab        <= '0;
            r_paint_ok    <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_paint_ok <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_hall_prev <= i_hall_level;
                    end
                end
                S_EDGE: begin
                    r_cycle_start <= r_now;
                    if (w_spur || w_miss) begin
                        r_stab <= '0;
                    end
                end
                S_RETIME: begin
                    r_avg <= r_nt;
                    if (w_nt_diff > VAL_W'(w_slack)) begin
                        r_stab     <= r_stab >> 1;
                        r_period   <= r_nt;
                        r_paint_ok <= 1'b0;
                    end else if (r_stab != STAB_MAX) begin
                        r_stab <= r_stab + STAB_W'(1);
                    end
                end
                S_PAINT_WAIT: begin
                    if (!w_div_busy) begin
                        r_paint_ok <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Item registers: timestamp, event, blended average, paint interval, slice position
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_now   <= i_now_us;
                    r_event <= EV_NONE;
                end
            end
            S_EDGE: begin
                if (w_spur) begin
                    r_event <= EV_SPURIOUS;
                end else if (w_miss) begin
                    r_event <= EV_MISSED;
                end
            end
            S_BLEND: begin
                if (!w_div_busy) begin
                    r_nt <= w_nt_sat;
                end
            end
            S_RETIME: begin
                r_event <= (w_nt_diff > VAL_W'(w_slack)) ? EV_RETIMED : EV_STEADY;
            end
            S_PAINT_WAIT: begin
                if (!w_div_busy) begin
                    r_paint <= w_div_quot[VAL_W-1:0];
                end
            end
            S_MOD: begin
                if (r_period == '0) begin
                    r_u <= '0;
                end
            end
            S_MOD_WAIT: begin
                if (!w_div_busy) begin
                    r_u <= w_div_rem;
                end
            end
            S_SPLIT: begin
                if (r_u < w_half_period) begin
                    r_x   <= r_u;
                    r_d   <= w_half_period;
                    r_mir <= 1'b0;
                end else begin
                    r_x   <= r_u - w_half_period;
                    r_d   <= r_period - w_half_period;
                    r_mir <= 1'b1;
                end
            end
            S_SLICE: begin
                if (r_d == '0) begin
                    r_slice <= '0;
                end
            end
            S_SLICE_WAIT: begin
                if (!w_div_busy) begin
                    r_slice <= SLICE_W'(w_div_quot);
                end
            end
            default: ;
        endcase
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_slice  <= r_slice;
            r_out_mir    <= r_mir;
            r_out_event  <= r_event;
            r_out_period <= r_period;
            r_out_paint  <= r_paint;
            r_out_stab   <= r_stab;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_slice_index       = r_out_slice;
    assign o_mirrored          = r_out_mir;
    assign o_event_res         = r_out_event;
    assign o_period_us         = r_out_period;
    assign o_paint_interval_us = r_out_paint;
    assign o_stable_count      = r_out_stab;

endmodule

`default_nettype wire

/* hw/rtl/rps_checker.sv */
// Port-level checks of the rotation period and slice tracker, bound to the top level.
`default_nettype none

module rps_checker
    import rps_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [SLICE_W-1:0] o_slice_index,
    input wire logic               o_mirrored,
    input wire logic [EVENT_W-1:0] o_event_res,
    input wire logic [VAL_W-1:0]   o_period_us,
    input wire logic [STAB_W-1:0]  o_stable_count
);

    // A stalled transaction keeps its valid and period
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_period_us))
        else $error("result changed while stalled");

    // A rejected edge clears the stability counter
    a_reject_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_SPURIOUS || o_event_res == EV_MISSED)
        |-> o_stable_count == '0)
        else $error("rejected edge left stability nonzero");

    // A steady edge always leaves a nonzero stability counter
    a_steady_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res == EV_STEADY |-> o_stable_count != '0)
        else $error("steady edge with zero stability");

    // A zero period reports the first slice of the mirrored half
    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_period_us == '0 |-> o_mirrored && o_slice_index == '0)
        else $error("zero period gave a wrong slice");

endmodule

bind rotation_period_slice_tracker rps_checker u_rps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_slice_index  (o_slice_index),
    .o_mirrored     (o_mirrored),
    .o_event_res    (o_event_res),
    .o_period_us    (o_period_us),
    .o_stable_count (o_stable_count)
);

`default_nettype wire
